// ----- rtl/core/envkv_pkg.sv -----
// ----------------------------------------------------------------------------
// envkv_pkg
// Shared types and constants of the environment key/value lookup.
// ----------------------------------------------------------------------------
package envkv_pkg;

  localparam int DEF_MAX_KEY = 16;
  localparam int POS_W       = 5;
  localparam int LEN_W       = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd2;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_ENDED = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  typedef enum logic [5:0] {
    PH_SEEK      = 6'b000001,
    PH_NAME      = 6'b000010,
    PH_SKIP_SEMI = 6'b000100,
    PH_VAL_SKIP  = 6'b001000,
    PH_VALUE     = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [POS_W-1:0] name_position;
    logic             name_matches;
  } scan_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value_byte;
    logic [1:0] kind;
    logic       run_end;
  } scan_result_t;

endpackage

// ----- rtl/core/envkv_scan.sv -----
// ----------------------------------------------------------------------------
// envkv_scan
// Next-state and result logic for one character of the environment string.
// ----------------------------------------------------------------------------
module envkv_scan #(
  parameter int MAX_KEY = envkv_pkg::DEF_MAX_KEY
) (
  input  envkv_pkg::scan_state_t           state,
  input  logic [envkv_pkg::LEN_W-1:0]      key_length,
  input  logic [MAX_KEY-1:0][7:0]          key_chars,
  input  logic [7:0]                       char_byte,
  input  logic                             is_end,
  output envkv_pkg::scan_state_t           state_next,
  output envkv_pkg::scan_result_t          res
);
  import envkv_pkg::*;

  localparam int IDX_W = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KEY);
  localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  logic             ended;
  logic             semi;
  logic             stop;
  logic             len_ok;
  logic             hit;
  logic [7:0]       kc;
  logic             mismatch;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] fresh_inc;
  logic             fresh_mismatch;

  assign ended  = is_end || (char_byte == 8'h00);
  assign semi   = !ended && (char_byte == CH_SEMI);
  assign stop   = ended || char_byte == CH_SPACE || char_byte == CH_TAB ||
                  char_byte == CH_EQ || char_byte == CH_SEMI;
  assign len_ok = (key_length != '0) && (key_length <= MAX_LEN);

  // key character at the current name position
  assign kc = (state.name_position < POS_W'(MAX_KEY)) ?
              key_chars[state.name_position[IDX_W-1:0]] : 8'h00;
  assign mismatch = (key_length > MAX_LEN) || (state.name_position >= key_length) ||
                    (kc != char_byte);
  assign pos_inc  = (state.name_position != POS_SAT) ? state.name_position + 1'b1 :
                    state.name_position;

  // first character of a new name sits at position zero
  assign fresh_mismatch = (key_length > MAX_LEN) || (key_length == '0) ||
                          (key_chars[0] != char_byte);
  assign fresh_inc = POS_W'(1);

  assign hit = state.name_matches && len_ok && (state.name_position == key_length);

  always_comb begin
    state_next     = state;
    res.valid      = 1'b0;
    res.value_byte = 8'h00;
    res.kind       = KIND_NONE;
    res.run_end    = 1'b0;
    case (state.phase)
      PH_SEEK: begin
        if (ended) begin
          res.valid   = 1'b1;
          res.kind    = KIND_NONE;
          res.run_end = 1'b1;
        end else if (is_alnum(char_byte)) begin
          state_next.phase         = PH_NAME;
          state_next.name_position = fresh_inc;
          state_next.name_matches  = !fresh_mismatch;
        end
      end
      PH_NAME: begin
        if (!stop) begin
          state_next.name_position = pos_inc;
          state_next.name_matches  = state.name_matches && !mismatch;
        end else if (hit) begin
          if (ended) begin
            state_next.phase = PH_SEEK;
            res.valid        = 1'b1;
            res.kind         = KIND_EMPTY;
            res.run_end      = 1'b1;
          end else begin
            state_next.phase = PH_VAL_SKIP;
          end
        end else if (ended) begin
          state_next.phase = PH_SEEK;
          res.valid        = 1'b1;
          res.kind         = KIND_NONE;
          res.run_end      = 1'b1;
        end else begin
          state_next.phase = semi ? PH_SEEK : PH_SKIP_SEMI;
        end
      end
      PH_SKIP_SEMI: begin
        if (ended) begin
          state_next.phase = PH_SEEK;
          res.valid        = 1'b1;
          res.kind         = KIND_NONE;
          res.run_end      = 1'b1;
        end else if (semi) begin
          state_next.phase = PH_SEEK;
        end
      end
      PH_VAL_SKIP: begin
        if (ended) begin
          state_next.phase = PH_SEEK;
          res.valid        = 1'b1;
          res.kind         = KIND_EMPTY;
          res.run_end      = 1'b1;
        end else if (is_alnum(char_byte)) begin
          state_next.phase = PH_VALUE;
          res.valid        = 1'b1;
          res.value_byte   = char_byte;
          res.kind         = KIND_BYTE;
        end
      end
      PH_VALUE: begin
        res.valid = 1'b1;
        if (ended) begin
          state_next.phase = PH_SEEK;
          res.kind         = KIND_ENDED;
          res.run_end      = 1'b1;
        end else if (semi) begin
          state_next.phase = PH_DONE;
          res.kind         = KIND_ENDED;
          res.run_end      = 1'b1;
        end else begin
          res.value_byte = char_byte;
          res.kind       = KIND_BYTE;
        end
      end
      PH_DONE: begin
        if (ended) begin
          state_next.phase = PH_SEEK;
        end
      end
      default: begin
        state_next.phase = PH_SEEK;
      end
    endcase
  end

endmodule

// ----- rtl/core/env_key_value_lookup.sv -----
// ----------------------------------------------------------------------------
// env_key_value_lookup
// Streams an environment string and returns the value of the configured key.
// ----------------------------------------------------------------------------
// The block takes one character per clock with no bubbles while the output is
// not stalled full: the scan state advances at the edge that accepts a
// character, and any result is written to the output register at that same
// edge. A character is taken even while a result waits, as long as that result
// is leaving in the same cycle; only a stalled full output register holds the
// input. Write the key registers only while no lookup is in flight.
module env_key_value_lookup #(
  parameter int MAX_KEY = envkv_pkg::DEF_MAX_KEY
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [envkv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [envkv_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      char_byte,
  input  logic                            is_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      value_byte,
  output logic [1:0]                      kind,
  output logic                            run_end
);
  import envkv_pkg::*;

  logic [LEN_W-1:0]       key_length;
  logic [MAX_KEY-1:0][7:0] key_chars;
  scan_state_t            state;
  scan_state_t            state_next;
  scan_result_t           res;
  logic                   in_accept;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  envkv_scan #(
    .MAX_KEY(MAX_KEY)
  ) u_scan (
    .state      (state),
    .key_length (key_length),
    .key_chars  (key_chars),
    .char_byte  (char_byte),
    .is_end     (is_end),
    .state_next (state_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      key_chars  <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_KEY_LENGTH) begin
        key_length <= cfg_data[LEN_W-1:0];
      end
      for (int i = 0; i < MAX_KEY; i++) begin
        if (i < 8 && cfg_index == CFG_KEY_LOW) begin
          key_chars[i] <= cfg_data[8*(i%8) +: 8];
        end
        if (i >= 8 && cfg_index == CFG_KEY_HIGH) begin
          key_chars[i] <= cfg_data[8*(i%8) +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_SEEK;
      state.name_position <= '0;
      state.name_matches  <= 1'b1;
      out_valid           <= 1'b0;
    end else if (in_accept) begin
      state     <= state_next;
      out_valid <= res.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res.valid) begin
      value_byte <= res.value_byte;
      kind       <= res.kind;
      run_end    <= res.run_end;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_run_end_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_end == (kind != KIND_BYTE)))
    else $error("run_end disagrees with kind");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_BYTE) |-> (value_byte == 8'h00))
    else $error("nonzero byte on a closing result");

  a_end_seek: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_end) |=> (state.phase == PH_SEEK))
    else $error("terminator did not restart the lookup");

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state.phase))
    else $error("phase register lost its one-hot code");

endmodule

// ----- dv/env_key_value_lookup_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_key_value_lookup_checker
// Watches the key writes and both channels of the lookup block, runs its own
// scan of every accepted character and compares each result with the oldest
// one predicted. Counts failures and reports how many results are in flight.
// ----------------------------------------------------------------------------
module env_key_value_lookup_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [envkv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [envkv_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      char_byte,
  input  logic                            is_end,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      value_byte,
  input  logic [1:0]                      kind,
  input  logic                            run_end,
  output int                              fail_count,
  output int                              pending,
  output int                              chars_taken,
  output int                              value_bytes,
  output int                              lookups_done
);
  import envkv_pkg::*;

  typedef struct packed {
    logic [7:0] vbyte;
    logic [1:0] kind;
    logic       last;
  } scan_out_t;

  scan_out_t pending_results [$];

  logic [LEN_W-1:0] key_len;
  logic [63:0]      key_lo;
  logic [63:0]      key_hi;

  phase_t           scan_phase;
  logic [POS_W-1:0] name_pos;
  logic             name_ok;

  scan_out_t        want;
  scan_out_t        got;
  scan_out_t        predicted;
  logic             produced;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic scan_out_t make_out(input logic [7:0] b, input logic [1:0] k,
                                         input logic l);
    scan_out_t r;
    r.vbyte = b;
    r.kind  = k;
    r.last  = l;
    return r;
  endfunction

  function automatic logic [7:0] key_char_at(input logic [POS_W-1:0] pos);
    return pos[3] ? key_hi[pos[2:0]*8 +: 8] : key_lo[pos[2:0]*8 +: 8];
  endfunction

  task take_name_char(input logic [7:0] c);
    if (key_len > DEF_MAX_KEY || name_pos >= key_len || key_char_at(name_pos) != c)
      name_ok = 1'b0;
    if (name_pos < 31)
      name_pos = name_pos + 1'b1;
  endtask

  task scan_char(input logic [7:0] c, input logic term, output logic made,
                 output scan_out_t res);
    logic at_end;
    logic semi;
    logic stop;
    logic hit;
    at_end = term || (c == 8'h00);
    semi   = !at_end && (c == CH_SEMI);
    made   = 1'b0;
    res    = '0;
    case (scan_phase)
      PH_SEEK: begin
        if (at_end) begin
          made = 1'b1;
          res  = make_out(8'h00, KIND_NONE, 1'b1);
        end else if (is_alnum(c)) begin
          name_pos = '0;
          name_ok  = 1'b1;
          take_name_char(c);
          scan_phase = PH_NAME;
        end
      end
      PH_NAME: begin
        stop = at_end || c == CH_SPACE || c == CH_TAB || c == CH_EQ || c == CH_SEMI;
        hit  = name_ok && key_len >= 1 && key_len <= DEF_MAX_KEY && name_pos == key_len;
        if (!stop) begin
          take_name_char(c);
        end else if (hit && at_end) begin
          scan_phase = PH_SEEK;
          made = 1'b1;
          res  = make_out(8'h00, KIND_EMPTY, 1'b1);
        end else if (hit) begin
          scan_phase = PH_VAL_SKIP;
        end else if (at_end) begin
          scan_phase = PH_SEEK;
          made = 1'b1;
          res  = make_out(8'h00, KIND_NONE, 1'b1);
        end else begin
          scan_phase = semi ? PH_SEEK : PH_SKIP_SEMI;
        end
      end
      PH_SKIP_SEMI: begin
        if (at_end) begin
          scan_phase = PH_SEEK;
          made = 1'b1;
          res  = make_out(8'h00, KIND_NONE, 1'b1);
        end else if (semi) begin
          scan_phase = PH_SEEK;
        end
      end
      PH_VAL_SKIP: begin
        if (at_end) begin
          scan_phase = PH_SEEK;
          made = 1'b1;
          res  = make_out(8'h00, KIND_EMPTY, 1'b1);
        end else if (is_alnum(c)) begin
          scan_phase = PH_VALUE;
          made = 1'b1;
          res  = make_out(c, KIND_BYTE, 1'b0);
        end
      end
      PH_VALUE: begin
        made = 1'b1;
        if (at_end) begin
          scan_phase = PH_SEEK;
          res = make_out(8'h00, KIND_ENDED, 1'b1);
        end else if (semi) begin
          scan_phase = PH_DONE;
          res = make_out(8'h00, KIND_ENDED, 1'b1);
        end else begin
          res = make_out(c, KIND_BYTE, 1'b0);
        end
      end
      PH_DONE: begin
        if (at_end)
          scan_phase = PH_SEEK;
      end
      default: scan_phase = PH_SEEK;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_len    = '0;
      key_lo     = '0;
      key_hi     = '0;
      scan_phase = PH_SEEK;
      name_pos   = '0;
      name_ok    = 1'b1;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = make_out(value_byte, kind, run_end);
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result byte %02h kind %0d end %0b",
                     $realtime, got.vbyte, got.kind, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: result mismatch, expected byte %02h kind %0d end %0b, ",
                        "got byte %02h kind %0d end %0b"},
                       $realtime, want.vbyte, want.kind, want.last,
                       got.vbyte, got.kind, got.last);
          end
          if (want.kind == KIND_BYTE)
            value_bytes++;
          if (want.last)
            lookups_done++;
        end
      end
      if (in_valid && !in_stall) begin
        chars_taken++;
        scan_char(char_byte, is_end, produced, predicted);
        if (produced)
          pending_results.push_back(predicted);
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_KEY_LENGTH: key_len = cfg_data[LEN_W-1:0];
          CFG_KEY_LOW:    key_lo  = cfg_data;
          CFG_KEY_HIGH:   key_hi  = cfg_data;
          default: ;
        endcase
      end
    end
    pending = pending_results.size();
  end

endmodule

// ----- dv/env_key_value_lookup_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_key_value_lookup_tb
// Feeds environment strings one character per item into the lookup block,
// with random gaps and output stalls, across a series of key settings. A
// short directed part hits the special cases, then random lookups built from
// matching, near-matching and unrelated names follow, mixed with noise.
// ----------------------------------------------------------------------------
module env_key_value_lookup_tb;
  import envkv_pkg::*;

  localparam int ITEM_TARGET = 1550;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           char_byte;
  logic                 is_end;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           value_byte;
  logic [1:0]           kind;
  logic                 run_end;

  int fail_count;
  int pending;
  int chars_taken;
  int value_bytes;
  int lookups_done;

  int         key_len;
  logic [7:0] key_text [16];
  bit         calm;
  int         items_sent;
  int         settings_used;

  always #6 clk = ~clk;

  env_key_value_lookup i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_byte  (char_byte),
    .is_end     (is_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_byte (value_byte),
    .kind       (kind),
    .run_end    (run_end)
  );

  env_key_value_lookup_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_byte    (char_byte),
    .is_end       (is_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value_byte   (value_byte),
    .kind         (kind),
    .run_end      (run_end),
    .fail_count   (fail_count),
    .pending      (pending),
    .chars_taken  (chars_taken),
    .value_bytes  (value_bytes),
    .lookups_done (lookups_done)
  );

  initial begin
    #10_000_000;
    $display("[env_key_value_lookup] ERROR");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 62)
      return 0;
    else if (r < 88)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 10);
    else
      return $urandom_range(20, 45);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10)
      return 8'h30 + 8'(r);
    else if (r < 36)
      return 8'h41 + 8'(r - 10);
    else
      return 8'h61 + 8'(r - 36);
  endfunction

  // nonzero byte outside 0-9, A-Z, a-z
  function automatic logic [7:0] rand_other();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(1, 47));
      1:       return 8'($urandom_range(58, 64));
      2:       return 8'($urandom_range(91, 96));
      default: return 8'($urandom_range(123, 255));
    endcase
  endfunction

  // out side stalls
  initial begin
    int s;
    int f;
    out_stall <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      s = idle_len();
      f = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (s > 0) begin
        out_stall <= 1'b1;
        repeat (s) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat (f) @(posedge clk);
    end
  end

  task push_char(input logic [7:0] c, input logic term);
    int  gap;
    bit  took;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_byte <= c;
    is_end    <= term;
    items_sent++;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
  endtask

  // string content, now and then corrupted
  task push_text(input logic [7:0] c);
    if ($urandom_range(0, 39) == 0)
      c = 8'($urandom_range(0, 255));
    push_char(c, 1'b0);
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], 1'b0);
  endtask

  task load_key(input logic [63:0] len_word, input logic [63:0] lo, input logic [63:0] hi);
    cfg_write <= 1'b1;
    cfg_index <= CFG_KEY_LENGTH;
    cfg_data  <= len_word;
    @(posedge clk);
    cfg_index <= CFG_KEY_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_KEY_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_write <= 1'b0;
    key_len = int'(len_word[LEN_W-1:0]);
    for (int i = 0; i < 8; i++) begin
      key_text[i]     = lo[8*i +: 8];
      key_text[8 + i] = hi[8*i +: 8];
    end
    settings_used++;
  endtask

  task settle(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task send_lookup();
    int  entries;
    int  n;
    int  r;
    bit  key_ok;
    key_ok = key_len >= 1 && key_len <= DEF_MAX_KEY;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(3, 15);
      for (int i = 0; i < n; i++)
        push_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    end else begin
      entries = $urandom_range(1, 4);
      for (int e = 0; e < entries; e++) begin
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, 2);
          for (int i = 0; i < n; i++)
            push_text(rand_other());
        end
        r = $urandom_range(0, 99);
        if (r < 40 && key_ok) begin
          for (int i = 0; i < key_len; i++)
            push_text(key_text[i]);
        end else if (r < 55 && key_ok && key_len > 1) begin
          n = $urandom_range(1, key_len - 1);
          for (int i = 0; i < n; i++)
            push_text(key_text[i]);
        end else if (r < 70 && key_ok) begin
          for (int i = 0; i < key_len; i++)
            push_text(key_text[i]);
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            push_text(rand_alnum());
        end else begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
          for (int i = 0; i < n; i++)
            push_text(rand_alnum());
        end
        r = $urandom_range(0, 99);
        if (r < 70)
          push_text(CH_EQ);
        else if (r < 78)
          push_text(CH_SPACE);
        else if (r < 84)
          push_text(CH_TAB);
        else if (r < 92)
          push_text(CH_SEMI);
        if ($urandom_range(0, 4) == 0)
          push_text(rand_other());
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          push_text(($urandom_range(0, 99) < 85) ? rand_alnum() : rand_other());
        if (e < entries - 1 || $urandom_range(0, 1) == 0)
          push_text(CH_SEMI);
      end
    end
    if ($urandom_range(0, 6) == 0)
      push_char(8'h00, 1'b0);
    else
      push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    logic [63:0] len_word;
    logic [63:0] lo;
    logic [63:0] hi;
    int          n;
    cfg_write <= 1'b0;
    cfg_index <= CFG_KEY_LENGTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    char_byte <= '0;
    is_end    <= 1'b0;
    calm = 1'b0;
    items_sent = 0;
    settings_used = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // key "AB"
    load_key(64'd2, 64'h0000_0000_0000_4241, 64'hffff_ffff_ffff_ffff);
    // found but empty, ';' after the name skipped
    send_text("AB\t;");
    push_char(8'ha5, 1'b1);
    // longer name mismatches, then a value ended at ';' and the tail ignored
    send_text("ABC=1;AB=v;");
    push_char(8'h00, 1'b1);
    // nothing found, terminator byte ignored
    push_char(8'hff, 1'b0);
    push_char(8'hff, 1'b1);
    // zero byte ends the string
    push_char("q", 1'b0);
    push_char(8'h00, 1'b0);
    // value ended by the terminator
    send_text("AB x");
    push_char(8'h00, 1'b1);
    settle(4);

    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      case (ph)
        0:       len_word = 64'd16;
        1:       len_word = 64'd0;
        2:       len_word = 64'd31;
        3:       len_word = 64'd1;
        default: begin
          n = $urandom_range(0, 99);
          if (n < 5)
            len_word = 64'd0;
          else if (n < 15)
            len_word = 64'd16;
          else if (n < 20)
            len_word = 64'($urandom_range(17, 31));
          else if (n < 30)
            len_word = 64'd1;
          else
            len_word = 64'($urandom_range(2, 8));
        end
      endcase
      if ($urandom_range(0, 4) == 0)
        len_word = len_word | ({$urandom, $urandom} & ~64'h1f);
      if ($urandom_range(0, 4) == 0) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end else begin
        for (int i = 0; i < 8; i++) begin
          lo[8*i +: 8] = rand_alnum();
          hi[8*i +: 8] = rand_alnum();
        end
      end
      load_key(len_word, lo, hi);
      calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(3, 10);
      for (int i = 0; i < n; i++)
        send_lookup();
      settle(4);
    end

    calm = 1'b0;
    settle(8);
    $display("ran %0d characters through %0d key settings", chars_taken, settings_used);
    $display("checked %0d value bytes and %0d finished lookups", value_bytes, lookups_done);
    if (fail_count == 0)
      $display("[env_key_value_lookup] OK");
    else
      $display("[env_key_value_lookup] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/envkv_pkg.sv
rtl/core/envkv_scan.sv
rtl/core/env_key_value_lookup.sv
dv/env_key_value_lookup_checker.sv
dv/env_key_value_lookup_tb.sv
